/* rtl/hrs_pkg.sv */
package hrs_pkg;

  // table geometry
  localparam int MAX_SLOTS = 64;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int SLOT_W    = 7;
  localparam int ID_W      = 32;
  localparam int CNT_W     = 3;
  localparam int TIMER_W   = 24;
  localparam int TICK16_W  = 16;
  localparam int ENTRY_W   = ID_W + 2 + 2 * CNT_W;

  // configuration port
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEVICE_COUNT = 3'd0,
    REG_PERIOD       = 3'd1,
    REG_REPLY_WAIT   = 3'd2,
    REG_GAP_OK       = 3'd3,
    REG_GAP_FAIL     = 3'd4,
    REG_RETRY_LIMIT  = 3'd5,
    REG_MISS_LIMIT   = 3'd6
  } reg_idx_t;

  localparam logic [SLOT_W-1:0]   DEVICE_COUNT_RST = 7'd0;
  localparam logic [TIMER_W-1:0]  PERIOD_RST       = 24'd9000;
  localparam logic [TICK16_W-1:0] REPLY_WAIT_RST   = 16'd20;
  localparam logic [TICK16_W-1:0] GAP_OK_RST       = 16'd20;
  localparam logic [TICK16_W-1:0] GAP_FAIL_RST     = 16'd30;
  localparam logic [CNT_W-1:0]    RETRY_LIMIT_RST  = 3'd6;
  localparam logic [CNT_W-1:0]    MISS_LIMIT_RST   = 3'd5;

  // request kinds on the input stream
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_REPLY = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // event kinds on the output stream
  typedef enum logic [1:0] {
    EV_REQ = 2'd0,
    EV_ON  = 2'd1,
    EV_OFF = 2'd2
  } ev_t;

  // supervision phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_WAIT_DONE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             bound;
    logic             reply;
    logic [CNT_W-1:0] retry;
    logic [CNT_W-1:0] miss;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } tbl_wr_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   device_count;
    logic [TIMER_W-1:0]  period;
    logic [TICK16_W-1:0] reply_wait;
    logic [TICK16_W-1:0] gap_ok;
    logic [TICK16_W-1:0] gap_fail;
    logic [CNT_W-1:0]    retry_limit;
    logic [CNT_W-1:0]    miss_limit;
  } cfg_t;

endpackage

/* rtl/hrs_ram.sv */
module hrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hrs_table.sv */
module hrs_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hrs_pkg::IDX_W-1:0]   rd_idx,
  output hrs_pkg::entry_t             rd_entry,
  input  hrs_pkg::tbl_wr_t            wr
);

  logic [hrs_pkg::MAX_SLOTS-1:0] valid;
  logic                          rd_valid;
  logic [hrs_pkg::ENTRY_W-1:0]   ram_rdata;

  hrs_ram #(
    .WIDTH (hrs_pkg::ENTRY_W),
    .DEPTH (hrs_pkg::MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.entry),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // per-slot written marks; an unwritten slot reads as an empty entry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // valid mark follows the read data through the same latency
  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_idx];
  end

  assign rd_entry = rd_valid ? hrs_pkg::entry_t'(ram_rdata) : '0;

endmodule

/* rtl/hrs_cfg.sv */
module hrs_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hrs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [hrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hrs_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  // register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_count <= hrs_pkg::DEVICE_COUNT_RST;
      cfg.period       <= hrs_pkg::PERIOD_RST;
      cfg.reply_wait   <= hrs_pkg::REPLY_WAIT_RST;
      cfg.gap_ok       <= hrs_pkg::GAP_OK_RST;
      cfg.gap_fail     <= hrs_pkg::GAP_FAIL_RST;
      cfg.retry_limit  <= hrs_pkg::RETRY_LIMIT_RST;
      cfg.miss_limit   <= hrs_pkg::MISS_LIMIT_RST;
    end else if (cfg_valid) begin
      case (hrs_pkg::reg_idx_t'(cfg_index))
        hrs_pkg::REG_DEVICE_COUNT: cfg.device_count <= cfg_data[hrs_pkg::SLOT_W-1:0];
        hrs_pkg::REG_PERIOD:       cfg.period       <= cfg_data[hrs_pkg::TIMER_W-1:0];
        hrs_pkg::REG_REPLY_WAIT:   cfg.reply_wait   <= cfg_data[hrs_pkg::TICK16_W-1:0];
        hrs_pkg::REG_GAP_OK:       cfg.gap_ok       <= cfg_data[hrs_pkg::TICK16_W-1:0];
        hrs_pkg::REG_GAP_FAIL:     cfg.gap_fail     <= cfg_data[hrs_pkg::TICK16_W-1:0];
        hrs_pkg::REG_RETRY_LIMIT:  cfg.retry_limit  <= cfg_data[hrs_pkg::CNT_W-1:0];
        hrs_pkg::REG_MISS_LIMIT:   cfg.miss_limit   <= cfg_data[hrs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/heartbeat_retry_supervisor_core.sv */
// Heartbeat supervisor with retries over a table of up to 64 device slots.
// Input stream (s_t*): one request per beat, kind in s_tuser: time tick,
// reply received or table slot write. Output stream (m_t*): heartbeat
// request, device online or device offline events, at most one per input beat.
// Config channel (cfg_*): register index and data, always ready; write only
// while the block is idle.
// Sequencing: a table write is done when the beat is taken; a reply reads,
// then writes the slot entry. A tick that ends a reply wait reads the entry,
// then writes back its counters where needed and may hand over an event. A
// tick that ends a period or pause starts a scan that reads one table entry
// per cycle through the single RAM read port, then may hand over a heartbeat
// request. Other ticks only step the timer. The next beat is taken once the
// current one is finished, even while its event still sits in the output register.
// Reset: synchronous, clears the table (per-slot written marks), phase,
// timer and registers to their defaults; no clearing pass is needed.
// Receiver stall: an event waits in the output register; a following event
// holds the sequencer (s_tready low) until the output register frees.
module heartbeat_retry_supervisor_core (
  input  logic                            clk,
  input  logic                            rst,
  // input beats
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [39:0]                     s_tdata,  // slot[6:0], device_id[38:7], bound[39]
  input  logic [1:0]                      s_tuser,  // req_type[1:0]
  // event beats
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,  // event_slot[6:0], event_device[38:7], zero[39]
  output logic [1:0]                      m_tuser,  // event_res[1:0]
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hrs_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [hrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = hrs_pkg::SLOT_W;

  hrs_pkg::cfg_t      cfg;
  hrs_pkg::entry_t    rd_entry;
  hrs_pkg::tbl_wr_t   wr;
  logic [hrs_pkg::IDX_W-1:0] rd_idx;

  hrs_pkg::state_t state, state_next;
  hrs_pkg::phase_t phase, phase_next;
  logic [hrs_pkg::TIMER_W-1:0]  timer, timer_next;
  logic [hrs_pkg::TICK16_W-1:0] gap_len, gap_len_next;
  logic [SW-1:0] current_slot, current_slot_next;
  logic [SW-1:0] work_slot, work_slot_next;
  hrs_pkg::ev_t                 ev_res, ev_res_next;
  logic [SW-1:0]                ev_slot, ev_slot_next;
  logic [hrs_pkg::ID_W-1:0]     ev_dev, ev_dev_next;

  // input fields
  hrs_pkg::req_t             in_req;
  logic [SW-1:0]             in_slot;
  logic [hrs_pkg::ID_W-1:0]  in_id;
  logic                      in_bound;
  logic                      in_slot_ok;

  logic [SW-1:0] rd_slot;
  logic [SW-1:0] rd_slot_m1;
  logic [SW-1:0] wr_slot_m1;
  logic [SW-1:0] last_slot;
  logic [SW-1:0] start_slot;
  logic [SW-1:0] work_slot_inc;
  logic          start_scan;
  logic [hrs_pkg::TIMER_W-1:0]  timer_inc;
  logic [hrs_pkg::TIMER_W-1:0]  period_eff;
  logic [hrs_pkg::TICK16_W-1:0] wait_eff;
  logic [hrs_pkg::TICK16_W-1:0] gap_eff;
  logic          out_free;
  logic          scan_hit;

  hrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hrs_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign in_slot    = s_tdata[SW-1:0];
  assign in_id      = s_tdata[SW+hrs_pkg::ID_W-1:SW];
  assign in_bound   = s_tdata[SW+hrs_pkg::ID_W];
  assign in_req     = hrs_pkg::req_t'(s_tuser);
  assign in_slot_ok = (in_slot != '0) && (in_slot <= SW'(hrs_pkg::MAX_SLOTS));

  assign last_slot = (cfg.device_count < SW'(hrs_pkg::MAX_SLOTS)) ?
                     cfg.device_count : SW'(hrs_pkg::MAX_SLOTS);

  // zero lengths last one tick
  assign period_eff = (cfg.period == '0) ? hrs_pkg::TIMER_W'(1) : cfg.period;
  assign wait_eff   = (cfg.reply_wait == '0) ? hrs_pkg::TICK16_W'(1) : cfg.reply_wait;
  assign gap_eff    = (gap_len == '0) ? hrs_pkg::TICK16_W'(1) : gap_len;
  assign timer_inc  = timer + hrs_pkg::TIMER_W'(1);

  assign work_slot_inc = work_slot + SW'(1);
  assign rd_slot_m1    = rd_slot - SW'(1);
  assign rd_idx        = rd_slot_m1[hrs_pkg::IDX_W-1:0];
  assign wr_slot_m1    = work_slot - SW'(1);
  assign scan_hit      = (rd_entry.id != '0) && !rd_entry.bound;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == hrs_pkg::ST_IDLE);

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hrs_pkg::ST_IDLE;
      phase        <= hrs_pkg::PH_IDLE;
      timer        <= '0;
      gap_len      <= '0;
      current_slot <= SW'(1);
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      timer        <= timer_next;
      gap_len      <= gap_len_next;
      current_slot <= current_slot_next;
    end
  end

  // working slot and pending event
  always_ff @(posedge clk) begin
    work_slot <= work_slot_next;
    ev_res    <= ev_res_next;
    ev_slot   <= ev_slot_next;
    ev_dev    <= ev_dev_next;
  end

  // next state, table access and events
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    timer_next        = timer;
    gap_len_next      = gap_len;
    current_slot_next = current_slot;
    work_slot_next    = work_slot;
    ev_res_next       = ev_res;
    ev_slot_next      = ev_slot;
    ev_dev_next       = ev_dev;
    rd_slot           = work_slot_inc;
    wr.en             = 1'b0;
    wr.idx            = wr_slot_m1[hrs_pkg::IDX_W-1:0];
    wr.entry          = rd_entry;
    start_scan        = 1'b0;
    start_slot        = current_slot;

    case (state)
      hrs_pkg::ST_IDLE: begin
        rd_slot = in_slot;
        if (s_tvalid) begin
          case (in_req)
            hrs_pkg::REQ_REPLY: begin
              if (in_slot_ok) begin
                work_slot_next = in_slot;
                state_next     = hrs_pkg::ST_REPLY;
              end
            end
            hrs_pkg::REQ_WRITE: begin
              if (in_slot_ok) begin
                wr.en          = 1'b1;
                wr.idx         = rd_idx;
                wr.entry       = '0;
                wr.entry.id    = in_id;
                wr.entry.bound = in_bound;
              end
            end
            hrs_pkg::REQ_TICK: begin
              case (phase)
                hrs_pkg::PH_WAIT: begin
                  rd_slot = current_slot;
                  if (timer_inc >= {{(hrs_pkg::TIMER_W-hrs_pkg::TICK16_W){1'b0}}, wait_eff}) begin
                    timer_next     = '0;
                    work_slot_next = current_slot;
                    state_next     = hrs_pkg::ST_WAIT_DONE;
                  end else begin
                    timer_next = timer_inc;
                  end
                end
                hrs_pkg::PH_GAP: begin
                  if (timer_inc >= {{(hrs_pkg::TIMER_W-hrs_pkg::TICK16_W){1'b0}}, gap_eff}) begin
                    start_scan = 1'b1;
                  end else begin
                    timer_next = timer_inc;
                  end
                end
                default: begin
                  phase_next = hrs_pkg::PH_IDLE;
                  start_slot = SW'(1);
                  if (timer_inc >= period_eff) begin
                    start_scan = 1'b1;
                  end else begin
                    timer_next = timer_inc;
                  end
                end
              endcase
              // first read of a scan goes out with the tick
              if (start_scan) begin
                rd_slot    = start_slot;
                timer_next = '0;
                if (start_slot <= last_slot) begin
                  work_slot_next = start_slot;
                  state_next     = hrs_pkg::ST_SCAN;
                end else begin
                  phase_next        = hrs_pkg::PH_IDLE;
                  current_slot_next = SW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end

      // reply: mark the slot as answered
      hrs_pkg::ST_REPLY: begin
        wr.en          = 1'b1;
        wr.entry.reply = 1'b1;
        state_next     = hrs_pkg::ST_IDLE;
      end

      // reply wait over: skip an empty or bound slot, online, retry, missed round or offline
      hrs_pkg::ST_WAIT_DONE: begin
        phase_next   = hrs_pkg::PH_GAP;
        gap_len_next = cfg.gap_fail;
        state_next   = hrs_pkg::ST_IDLE;
        ev_slot_next = work_slot;
        ev_dev_next  = rd_entry.id;
        if ((rd_entry.id == '0) || rd_entry.bound) begin
          current_slot_next = work_slot_inc;
        end else if (rd_entry.reply) begin
          wr.en             = 1'b1;
          wr.entry.miss     = '0;
          wr.entry.retry    = '0;
          ev_res_next       = hrs_pkg::EV_ON;
          current_slot_next = work_slot_inc;
          gap_len_next      = cfg.gap_ok;
          state_next        = hrs_pkg::ST_EMIT;
        end else if (rd_entry.retry < cfg.retry_limit) begin
          wr.en          = 1'b1;
          wr.entry.retry = rd_entry.retry + hrs_pkg::CNT_W'(1);
        end else begin
          wr.en             = 1'b1;
          wr.entry.retry    = '0;
          current_slot_next = work_slot_inc;
          if (rd_entry.miss < cfg.miss_limit) begin
            wr.entry.miss = rd_entry.miss + hrs_pkg::CNT_W'(1);
          end else begin
            wr.entry.miss = '0;
            ev_res_next   = hrs_pkg::EV_OFF;
            state_next    = hrs_pkg::ST_EMIT;
          end
        end
      end

      // one entry checked per cycle while the next one is read
      hrs_pkg::ST_SCAN: begin
        rd_slot = work_slot_inc;
        if (scan_hit) begin
          wr.en             = 1'b1;
          wr.entry.reply    = 1'b0;
          phase_next        = hrs_pkg::PH_WAIT;
          current_slot_next = work_slot;
          ev_res_next       = hrs_pkg::EV_REQ;
          ev_slot_next      = work_slot;
          ev_dev_next       = rd_entry.id;
          state_next        = hrs_pkg::ST_EMIT;
        end else if (work_slot_inc <= last_slot) begin
          work_slot_next = work_slot_inc;
        end else begin
          phase_next        = hrs_pkg::PH_IDLE;
          current_slot_next = SW'(1);
          state_next        = hrs_pkg::ST_IDLE;
        end
      end

      // hand the event to the output register
      hrs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = hrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = hrs_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == hrs_pkg::ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == hrs_pkg::ST_EMIT) && out_free) begin
      m_tdata <= {1'b0, ev_dev, ev_slot};
      m_tuser <= ev_res;
    end
  end

endmodule
